// File: hw/rtl/pgcd_pkg.sv
// Shared types, opcodes and a helper function for the packed geometry command decoder.
package pgcd_pkg;

   // Result kinds as they appear on the result channel.
   typedef enum logic [2:0] {
      KIND_MATRIX  = 3'd0,
      KIND_NORMAL  = 3'd1,
      KIND_TEX     = 3'd2,
      KIND_VERTEX  = 3'd3,
      KIND_BEGIN   = 3'd4,
      KIND_UNKNOWN = 3'd5
   } kind_type;

   // Opcode bytes that take parameter words.
   localparam logic [7:0] OP_MATRIX = 8'h19;
   localparam logic [7:0] OP_NORMAL = 8'h21;
   localparam logic [7:0] OP_TEX    = 8'h22;
   localparam logic [7:0] OP_VERTEX = 8'h24;
   localparam logic [7:0] OP_BEGIN  = 8'h40;

   // Number of words in a matrix load.
   localparam logic [3:0] MATRIX_WORDS = 4'd12;

   // 4x3 matrix, entry r*3+c holds row r, column c, each in 20.12.
   typedef logic [11:0][31:0] matrix_type;

   // Identity: entries 0, 4 and 8 hold 1.0.
   localparam matrix_type MATRIX_RESET = {
      32'd0, 32'd0, 32'd0, 32'd4096,
      32'd0, 32'd0, 32'd0, 32'd4096,
      32'd0, 32'd0, 32'd0, 32'd4096
   };

   // Work produced by the parser for one accepted word.
   typedef struct packed {
      logic        has_main;   // a completed opcode leads the results
      kind_type    kind;       // kind of the completed opcode
      logic [7:0]  opcode;     // opcode byte of the completed opcode
      logic [31:0] word;       // parameter word of the completed opcode
      logic [31:0] unk_ops;    // command word holding the unknown bytes
      logic [1:0]  unk_start;  // first unknown slot
      logic [2:0]  unk_count;  // number of unknown bytes that follow
   } job_type;

   // Queue entry: a job with its main result already formatted.
   typedef struct packed {
      logic               has_main;
      kind_type           kind;
      logic [7:0]         opcode;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic               strip;
      logic               sat;
      logic [31:0]        unk_ops;
      logic [1:0]         unk_start;
      logic [2:0]         unk_count;
   } entry_type;

   // One result transaction.
   typedef struct packed {
      kind_type           kind;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic [7:0]         opcode;
      logic               strip;
      logic               sat;
      logic               last;
   } rsp_type;

   // Parameter words owed by an opcode byte.
   function automatic logic [3:0] param_count(logic [7:0] op);
      logic [3:0] cnt;
      unique case (op)
         OP_MATRIX: cnt = MATRIX_WORDS;
         OP_NORMAL, OP_TEX, OP_VERTEX, OP_BEGIN: cnt = 4'd1;
         default: cnt = 4'd0;
      endcase
      return cnt;
   endfunction

endpackage

// File: hw/rtl/pgcd_parser.sv
// Front end: parses command and parameter words, holds the matrix and issues jobs.
module pgcd_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [31:0]          word,
   output logic                 job_valid,
   output pgcd_pkg::job_type    job,
   output pgcd_pkg::matrix_type matrix
);
   import pgcd_pkg::*;

   logic [31:0] pending_ff, pending_in;
   logic [1:0]  slot_ff, slot_in;
   logic        await_ff, await_in;
   logic [7:0]  active_ff, active_in;
   logic [3:0]  left_ff, left_in;
   matrix_type  matrix_ff;
   logic        mat_we;
   logic [3:0]  mat_idx;

   // Decode the word against the parser state and scan the remaining slots.
   always_comb begin
      logic [2:0]  scan_from;
      logic [31:0] scan_word;
      logic        do_scan;
      logic        main_done;
      logic        found;
      logic [1:0]  found_k;
      logic [7:0]  found_op;
      kind_type    main_kind;

      pending_in = pending_ff;
      slot_in    = slot_ff;
      await_in   = await_ff;
      active_in  = active_ff;
      left_in    = left_ff;
      mat_we     = 1'b0;
      mat_idx    = MATRIX_WORDS - left_ff;
      scan_from  = 3'd0;
      scan_word  = pending_ff;
      do_scan    = 1'b0;
      main_done  = 1'b0;
      found      = 1'b0;
      found_k    = 2'd0;
      found_op   = 8'd0;
      main_kind  = KIND_BEGIN;
      job        = '0;
      job_valid  = 1'b0;

      if (accept) begin
         if (await_ff || left_ff == 4'd0) begin
            // Command word: latch it and start at slot zero.
            pending_in = word;
            await_in   = 1'b0;
            do_scan    = 1'b1;
            scan_from  = 3'd0;
            scan_word  = word;
         end else begin
            // Parameter word for the active opcode.
            if (active_ff == OP_MATRIX) begin
               mat_we  = (left_ff >= 4'd1) && (left_ff <= MATRIX_WORDS);
               left_in = left_ff - 4'd1;
               if (left_ff == 4'd1) begin
                  main_done = 1'b1;
                  main_kind = KIND_MATRIX;
               end
            end else begin
               left_in   = 4'd0;
               main_done = 1'b1;
               priority if (active_ff == OP_NORMAL) begin
                  main_kind = KIND_NORMAL;
               end else if (active_ff == OP_TEX) begin
                  main_kind = KIND_TEX;
               end else if (active_ff == OP_VERTEX) begin
                  main_kind = KIND_VERTEX;
               end else begin
                  main_kind = KIND_BEGIN;
               end
            end
            if (main_done) begin
               if (slot_ff == 2'd3) begin
                  slot_in  = 2'd0;
                  await_in = 1'b1;
               end else begin
                  do_scan   = 1'b1;
                  scan_from = {1'b0, slot_ff} + 3'd1;
                  scan_word = pending_ff;
               end
            end
         end

         // Find the first slot from scan_from on that takes parameter words.
         for (int k = 3; k >= 0; k--) begin
            if (k >= int'(scan_from) && param_count(scan_word[8*k +: 8]) != 4'd0) begin
               found    = 1'b1;
               found_k  = 2'(k);
               found_op = scan_word[8*k +: 8];
            end
         end

         job.has_main  = main_done;
         job.kind      = main_kind;
         job.opcode    = active_ff;
         job.word      = word;
         job.unk_ops   = scan_word;
         job.unk_start = scan_from[1:0];
         job.unk_count = 3'd0;

         if (do_scan) begin
            if (found) begin
               job.unk_count = {1'b0, found_k} - scan_from;
               active_in     = found_op;
               left_in       = param_count(found_op);
               slot_in       = found_k;
               await_in      = 1'b0;
            end else begin
               job.unk_count = 3'd4 - scan_from;
               slot_in       = 2'd0;
               await_in      = 1'b1;
            end
         end

         job_valid = main_done || (job.unk_count != 3'd0);
      end
   end

   // Parser state.
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         slot_ff    <= '0;
         await_ff   <= 1'b1;
         active_ff  <= '0;
         left_ff    <= '0;
      end else begin
         pending_ff <= pending_in;
         slot_ff    <= slot_in;
         await_ff   <= await_in;
         active_ff  <= active_in;
         left_ff    <= left_in;
      end
   end

   // Matrix entries are written as each load word arrives.
   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_ff <= MATRIX_RESET;
      end else if (mat_we) begin
         matrix_ff[mat_idx] <= word;
      end
   end

   assign matrix = matrix_ff;

endmodule

// File: hw/rtl/pgcd_xform.sv
// Two-stage pipeline that formats main results and transforms vertices by the matrix.
module pgcd_xform (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_valid,
   input  pgcd_pkg::job_type    job,
   input  pgcd_pkg::matrix_type matrix,
   output logic                 entry_valid,
   output pgcd_pkg::entry_type  entry,
   output logic [1:0]           inflight
);
   import pgcd_pkg::*;

   localparam logic signed [44:0] SAT_MAX = 45'sh0_7FFF_FFFF;
   localparam logic signed [44:0] SAT_MIN = -45'sh0_8000_0000;

   logic               s1_v_ff;
   job_type            s1_job_ff;
   logic               s2_v_ff;
   job_type            s2_job_ff;
   logic signed [41:0] prod_ff [3][3];
   logic signed [41:0] prod_in [3][3];
   logic signed [31:0] trans_ff [3];
   logic signed [31:0] trans_in [3];

   // Stage one: the nine products and the translation row, against the current matrix.
   always_comb begin
      logic signed [9:0] coord [3];
      coord[0] = s1_job_ff.word[9:0];
      coord[1] = s1_job_ff.word[19:10];
      coord[2] = s1_job_ff.word[29:20];
      for (int j = 0; j < 3; j++) begin
         for (int r = 0; r < 3; r++) begin
            prod_in[j][r] = 42'(coord[r]) * 42'(signed'(matrix[4'(r*3 + j)]));
         end
         trans_in[j] = signed'(matrix[4'(9 + j)]);
      end
   end

   // Pipeline registers; the stages never stall, the top level holds room for them.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= job_valid;
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_job_ff <= job;
      s2_job_ff <= s1_job_ff;
      prod_ff   <= prod_in;
      trans_ff  <= trans_in;
   end

   // Stage two: column sums, floor shift, saturation and result formatting.
   always_comb begin
      logic signed [44:0] sum;
      logic signed [44:0] shifted;
      logic signed [31:0] col [3];
      logic               any_sat;
      logic [31:0]        w;

      any_sat = 1'b0;
      for (int j = 0; j < 3; j++) begin
         sum = 45'(prod_ff[j][0]) + 45'(prod_ff[j][1]) + 45'(prod_ff[j][2])
             + (45'(trans_ff[j]) <<< 6);
         shifted = sum >>> 6;
         if (shifted > SAT_MAX) begin
            col[j]  = 32'sh7FFF_FFFF;
            any_sat = 1'b1;
         end else if (shifted < SAT_MIN) begin
            col[j]  = 32'sh8000_0000;
            any_sat = 1'b1;
         end else begin
            col[j] = shifted[31:0];
         end
      end

      w               = s2_job_ff.word;
      entry           = '0;
      entry.has_main  = s2_job_ff.has_main;
      entry.kind      = s2_job_ff.kind;
      entry.opcode    = s2_job_ff.opcode;
      entry.unk_ops   = s2_job_ff.unk_ops;
      entry.unk_start = s2_job_ff.unk_start;
      entry.unk_count = s2_job_ff.unk_count;
      unique case (s2_job_ff.kind)
         KIND_VERTEX: begin
            entry.x   = col[0];
            entry.y   = col[1];
            entry.z   = col[2];
            entry.sat = any_sat;
         end
         KIND_NORMAL: begin
            entry.x = 32'(signed'(w[9:0]));
            entry.y = 32'(signed'(w[19:10]));
            entry.z = 32'(signed'(w[29:20]));
         end
         KIND_TEX: begin
            entry.x = {16'd0, w[15:0]};
            entry.y = {16'd0, w[31:16]};
         end
         KIND_BEGIN: begin
            entry.strip = |w;
         end
         default: begin
            entry.strip = 1'b0;
         end
      endcase
   end

   assign entry_valid = s2_v_ff;
   assign inflight    = {1'b0, s1_v_ff} + {1'b0, s2_v_ff};

endmodule

// File: hw/rtl/pgcd_fifo.sv
// Short queue of formatted entries between the front end and the result expander.
module pgcd_fifo #(
   parameter int DEPTH = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  pgcd_pkg::entry_type          push_entry,
   input  logic                         pop,
   output pgcd_pkg::entry_type          head,
   output logic                         empty,
   output logic [$clog2(DEPTH+1)-1:0]   count
);
   import pgcd_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   entry_type       mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_pop;

   assign do_pop = pop && (count_ff != '0);

   // Pointer and fill count update with wrap at the last entry.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head  = mem_ff[rd_ptr_ff];
   assign empty = (count_ff == '0);
   assign count = count_ff;

endmodule

// File: hw/rtl/pgcd_expand.sv
// Back end: expands each queue entry into its result transactions, one per cycle while results are popped.
module pgcd_expand (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  pgcd_pkg::entry_type head,
   output logic                head_pop,
   input  logic                rsp_pop,
   output logic                rsp_valid,
   output pgcd_pkg::rsp_type   rsp
);
   import pgcd_pkg::*;

   logic    [2:0] idx_ff, idx_in;
   logic          out_v_ff, out_v_in;
   rsp_type       rsp_ff, rsp_in;
   logic          load;
   logic          is_last;

   // Pick the result at idx_ff out of the head entry.
   always_comb begin
      logic [2:0] total;
      logic [2:0] u;
      logic [1:0] slot;
      logic       is_main;

      total   = {2'd0, head.has_main} + head.unk_count;
      is_main = head.has_main && (idx_ff == 3'd0);
      u       = idx_ff - {2'd0, head.has_main};
      slot    = head.unk_start + u[1:0];
      is_last = (idx_ff == total - 3'd1);

      rsp_in      = '0;
      rsp_in.last = is_last;
      if (is_main) begin
         rsp_in.kind   = head.kind;
         rsp_in.x      = head.x;
         rsp_in.y      = head.y;
         rsp_in.z      = head.z;
         rsp_in.opcode = head.opcode;
         rsp_in.strip  = head.strip;
         rsp_in.sat    = head.sat;
      end else begin
         rsp_in.kind   = KIND_UNKNOWN;
         rsp_in.opcode = head.unk_ops[{slot, 3'b000} +: 8];
      end
   end

   // The output register loads when it is free or being emptied this cycle.
   assign load     = head_valid && (!out_v_ff || rsp_pop);
   assign head_pop = load && is_last;

   always_comb begin
      idx_in   = idx_ff;
      out_v_in = out_v_ff;
      if (load) begin
         out_v_in = 1'b1;
         idx_in   = is_last ? 3'd0 : idx_ff + 3'd1;
      end else if (rsp_pop) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         out_v_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp       = rsp_ff;

endmodule

// File: hw/rtl/packed_geometry_command_decoder.sv
// Top level of the packed geometry command decoder: parser, transform, queue and expander.
//
//   Channel   Direction  Handshake         Payload
//   req_      in         push / full       word (32)
//   rsp_      out        empty / pop       kind, coord_x/y/z, opcode_seen, strip_mode,
//                                          saturated, last
//
// One word is accepted per cycle while the queue and the transform pipeline have room.
// An accepted word passes through both transform stages and the queue before the result register.
// The expander sends one result per cycle while results are popped, so a word causing k results holds it for all k.
// Synchronous reset sets the matrix to identity and empties every stage.
// full rises when queue entries plus jobs in the transform pipeline reach QUEUE_DEPTH.
module packed_geometry_command_decoder #(
   parameter int QUEUE_DEPTH = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [31:0]        req_word,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [2:0]         rsp_kind,
   output logic signed [31:0] rsp_coord_x,
   output logic signed [31:0] rsp_coord_y,
   output logic signed [31:0] rsp_coord_z,
   output logic [7:0]         rsp_opcode_seen,
   output logic               rsp_strip_mode,
   output logic               rsp_saturated,
   output logic               rsp_last
);
   import pgcd_pkg::*;

   localparam int FCW = $clog2(QUEUE_DEPTH + 1);
   localparam int OCW = $clog2(QUEUE_DEPTH + 3);

   logic             accept;
   logic             job_valid;
   job_type          job;
   matrix_type       matrix;
   logic             entry_valid;
   entry_type        entry;
   logic [1:0]       inflight;
   entry_type        head;
   logic             fifo_empty;
   logic [FCW-1:0]   fifo_count;
   logic             head_pop;
   logic             rsp_valid;
   rsp_type          rsp;
   logic [OCW-1:0]   occupancy;

   // Room is reserved for every job still in the transform pipeline.
   assign occupancy = OCW'(fifo_count) + OCW'(inflight);
   assign req_full  = (occupancy >= OCW'(QUEUE_DEPTH));
   assign accept    = req_push && !req_full;

   pgcd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .word      (req_word),
      .job_valid (job_valid),
      .job       (job),
      .matrix    (matrix)
   );

   pgcd_xform u_xform (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (job_valid),
      .job         (job),
      .matrix      (matrix),
      .entry_valid (entry_valid),
      .entry       (entry),
      .inflight    (inflight)
   );

   pgcd_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (entry_valid),
      .push_entry (entry),
      .pop        (head_pop),
      .head       (head),
      .empty      (fifo_empty),
      .count      (fifo_count)
   );

   pgcd_expand u_expand (
      .clock      (clock),
      .reset      (reset),
      .head_valid (!fifo_empty),
      .head       (head),
      .head_pop   (head_pop),
      .rsp_pop    (rsp_pop),
      .rsp_valid  (rsp_valid),
      .rsp        (rsp)
   );

   // Result ports.
   assign rsp_empty       = !rsp_valid;
   assign rsp_kind        = rsp.kind;
   assign rsp_coord_x     = rsp.x;
   assign rsp_coord_y     = rsp.y;
   assign rsp_coord_z     = rsp.z;
   assign rsp_opcode_seen = rsp.opcode;
   assign rsp_strip_mode  = rsp.strip;
   assign rsp_saturated   = rsp.sat;
   assign rsp_last        = rsp.last;

   // The queue never holds more entries than it has.
   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      fifo_count <= FCW'(QUEUE_DEPTH))
      else $error("queue fill count exceeds its depth");

   // An accepted word never pushes reserved occupancy past the queue depth.
   a_credit: assert property (@(posedge clock) disable iff (reset)
      accept |=> occupancy <= OCW'(QUEUE_DEPTH))
      else $error("transaction accepted without room in the queue");

   // Saturation is only reported on vertex results.
   a_sat_kind: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_saturated) |-> rsp_kind == KIND_VERTEX)
      else $error("saturated flag on a result that is not a vertex");

   // Strip mode is only reported on begin results.
   a_strip_kind: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_strip_mode) |-> rsp_kind == KIND_BEGIN)
      else $error("strip flag on a result that is not a begin");

endmodule
